FILE: rtl/text_line_justifier_assert.svh
// ----------------------------------------------------------------------------
// text_line_justifier_assert.svh
// Assertion macros shared by the line justifier modules. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_JUSTIFIER_ASSERT_SVH
`define TEXT_LINE_JUSTIFIER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define TLJ_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("text_line_justifier: implication check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define TLJ_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("text_line_justifier: next-cycle check failed");
`else
`define TLJ_ASSERT_IMP(label, ck, rn, ante, cons)
`define TLJ_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

FILE: rtl/tlj_pkg.sv
// ----------------------------------------------------------------------------
// tlj_pkg
// Shared constants, mode codes and the controller/datapath command and
// status bundles of the line justifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlj_pkg;

  // Fixed field widths.
  localparam int WORD_W = 7;
  localparam int SP_W   = 6;
  localparam int CFG_W  = 7;

  localparam logic [SP_W-1:0]  SP_MAX    = 6'd63;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // What kind of word the datapath is emitting.
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_FULL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LAST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OVS  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                div_start;
    logic                rd;
    logic                emit;
    logic                idx_clr;
    logic                idx_inc;
    logic                append;
    logic                line_clr;
    logic [MODE_W-1:0]   mode;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic oversize;
    logic flush_full;
    logic last_word;
    logic div_done;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/tlj_word_if.sv
// ----------------------------------------------------------------------------
// tlj_word_if
// Input channel: one word length per transfer, with the final-word mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tlj_word_if;
  logic                        valid;
  logic                        ready;
  logic [tlj_pkg::WORD_W-1:0]  word_length;
  logic                        last_word;

  modport source (output valid, output word_length, output last_word, input ready);
  modport sink (input valid, input word_length, input last_word, output ready);
endinterface

`default_nettype wire

FILE: rtl/tlj_result_if.sv
// ----------------------------------------------------------------------------
// tlj_result_if
// Result channel: one placed word per transfer with its trailing spaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tlj_result_if;
  logic                        valid;
  logic                        ready;
  logic [tlj_pkg::WORD_W-1:0]  out_word_length;
  logic [tlj_pkg::SP_W-1:0]    spaces_after;
  logic                        end_of_line;
  logic                        oversize;
  logic                        last_result;

  modport source (output valid, output out_word_length, output spaces_after,
                  output end_of_line, output oversize, output last_result,
                  input ready);
  modport sink (input valid, input out_word_length, input spaces_after,
                input end_of_line, input oversize, input last_result,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/text_line_justifier.sv
// ----------------------------------------------------------------------------
// text_line_justifier
// Greedy full justification of a stream of word lengths into lines.
// ----------------------------------------------------------------------------
// One input word is handled at a time. A word that joins the line without
// a flush passes through accept, fit check and buffer write. A flush of a
// full line starts the serial gap divider, waits while it works through
// every bit of the maximum line width, and then emits the buffered words;
// each word comes from the line buffer RAM via its registered read port
// before it enters the output register. The final line is emitted in the
// same way, while an oversize word goes to the output register after its
// fit check. Results wait in an output register, so a stalled consumer
// holds back only the next emission. The line width register may be written
// only while no word is being processed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_line_justifier #(
  parameter int MAX_LINE_WIDTH = 64,
  parameter int MAX_LINE_WORDS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [tlj_pkg::CFG_W-1:0]   cfg_wdata,
  tlj_word_if.sink                         in_chan,
  tlj_result_if.source                     out_chan
);

  tlj_pkg::cmd_t cmd;
  tlj_pkg::sts_t sts;
  logic          in_ready;

  // Sequencer.
  tlj_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  assign in_chan.ready = in_ready;

  // Datapath with line buffer and output register.
  tlj_datapath #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .MAX_LINE_WORDS (MAX_LINE_WORDS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_word_length   (in_chan.word_length),
    .in_last_word     (in_chan.last_word),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_word_length  (out_chan.out_word_length),
    .out_spaces_after (out_chan.spaces_after),
    .out_end_of_line  (out_chan.end_of_line),
    .out_oversize     (out_chan.oversize),
    .out_last_result  (out_chan.last_result)
  );

endmodule

`default_nettype wire

FILE: rtl/tlj_ram.sv
// ----------------------------------------------------------------------------
// tlj_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/tlj_datapath.sv
// ----------------------------------------------------------------------------
// tlj_datapath
// Line buffer, line counters, bit-serial gap divider, spacing arithmetic
// and the output register of the line justifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_line_justifier_assert.svh"

module tlj_datapath #(
  parameter int MAX_LINE_WIDTH = 64,
  parameter int MAX_LINE_WORDS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [tlj_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic [tlj_pkg::WORD_W-1:0]   in_word_length,
  input  wire logic                         in_last_word,
  input  wire tlj_pkg::cmd_t                cmd,
  output tlj_pkg::sts_t                     sts,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tlj_pkg::WORD_W-1:0]        out_word_length,
  output logic [tlj_pkg::SP_W-1:0]          out_spaces_after,
  output logic                              out_end_of_line,
  output logic                              out_oversize,
  output logic                              out_last_result
);

  localparam int LINE_CAP = (MAX_LINE_WORDS < 64) ? MAX_LINE_WORDS : 63;
  localparam int CW       = $clog2(LINE_CAP + 1);
  localparam int AW       = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
  localparam int WW       = $clog2(MAX_LINE_WIDTH + 1);
  localparam int XW       = WW + 7;
  localparam int IW       = $clog2(WW + 1);

  logic [tlj_pkg::CFG_W-1:0]  cfg_width_r;
  logic [WW-1:0]              eff_w;
  logic [tlj_pkg::WORD_W-1:0] len_r;
  logic                       last_r;
  logic [CW-1:0]              line_cnt_r;
  logic [WW-1:0]              letters_r;
  logic [AW-1:0]              idx_r;
  logic [WW-1:0]              num_r;
  logic [CW-1:0]              rem_r;
  logic [IW-1:0]              div_cnt_r;
  logic [tlj_pkg::WORD_W-1:0] ram_rdata;

  logic                       out_valid_r;
  logic [tlj_pkg::WORD_W-1:0] out_len_r;
  logic [tlj_pkg::SP_W-1:0]   out_sp_r;
  logic                       out_eol_r;
  logic                       out_ovs_r;
  logic                       out_lr_r;

  logic                       oversize;
  logic                       at_cap;
  logic                       overflow;
  logic                       idx_last;
  logic [WW-1:0]              spare;
  logic [CW-1:0]              gaps;
  logic [CW:0]                trial;
  logic [CW:0]                diff;
  logic                       ge;
  logic [XW-1:0]              base_sum;
  logic [XW-1:0]              used;
  logic [XW-1:0]              tail;

  logic [tlj_pkg::WORD_W-1:0] out_len_nxt;
  logic [tlj_pkg::SP_W-1:0]   out_sp_nxt;
  logic                       out_eol_nxt;
  logic                       out_ovs_nxt;
  logic                       out_lr_nxt;

  // Clamp a space count to the field range.
  function automatic logic [tlj_pkg::SP_W-1:0] sat_sp(input logic [XW-1:0] v);
    logic [tlj_pkg::SP_W-1:0] r;
    if (v > XW'(tlj_pkg::SP_MAX)) begin
      r = tlj_pkg::SP_MAX;
    end else begin
      r = v[tlj_pkg::SP_W-1:0];
    end
    return r;
  endfunction

  // Line width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r <= tlj_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_width_r <= cfg_wdata;
    end
  end

  // Effective width: zero acts as one, large values clamp to the maximum.
  always_comb begin
    if (cfg_width_r == '0) begin
      eff_w = WW'(1);
    end else if (XW'(cfg_width_r) > XW'(MAX_LINE_WIDTH)) begin
      eff_w = WW'(MAX_LINE_WIDTH);
    end else begin
      eff_w = WW'(cfg_width_r);
    end
  end

  // Accepted word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r  <= in_word_length;
      last_r <= in_last_word;
    end
  end

  // Line fill state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r <= '0;
      letters_r  <= '0;
    end else if (cmd.line_clr) begin
      line_cnt_r <= '0;
      letters_r  <= '0;
    end else if (cmd.append) begin
      line_cnt_r <= line_cnt_r + CW'(1);
      letters_r  <= WW'(XW'(letters_r) + XW'(len_r));
    end
  end

  // Emit index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // Word buffer of the current line.
  tlj_ram #(
    .WIDTH (tlj_pkg::WORD_W),
    .DEPTH (LINE_CAP),
    .AW    (AW)
  ) u_line_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (AW'(line_cnt_r)),
    .wdata (len_r),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Fit decisions for the held word.
  assign oversize = XW'(len_r) > XW'(eff_w);
  assign at_cap   = line_cnt_r >= CW'(LINE_CAP);
  assign overflow = (XW'(letters_r) + XW'(len_r) + XW'(line_cnt_r)) > XW'(eff_w);
  assign idx_last = CW'(idx_r) == (line_cnt_r - CW'(1));

  // Spare columns and gap count of the buffered line.
  assign spare = (eff_w > letters_r) ? (eff_w - letters_r) : '0;
  assign gaps  = line_cnt_r - CW'(1);

  // Restoring divider step: one quotient bit per cycle.
  assign trial = {rem_r, num_r[WW-1]};
  assign ge    = trial >= {1'b0, gaps};
  assign diff  = trial - {1'b0, gaps};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= IW'(WW);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r <= spare;
      rem_r <= '0;
    end else if (div_cnt_r != '0) begin
      num_r <= {num_r[WW-2:0], ge};
      rem_r <= ge ? diff[CW-1:0] : trial[CW-1:0];
    end
  end

  // Spacing: quotient plus one for the leftmost remainder gaps.
  assign base_sum = XW'(num_r) + XW'(CW'(idx_r) < rem_r);
  assign used     = XW'(letters_r) + XW'(line_cnt_r) - XW'(1);
  assign tail     = (XW'(eff_w) > used) ? (XW'(eff_w) - used) : '0;

  // Payload of the next result word.
  always_comb begin
    out_len_nxt = ram_rdata;
    out_sp_nxt  = '0;
    out_eol_nxt = idx_last;
    out_ovs_nxt = 1'b0;
    out_lr_nxt  = 1'b0;
    unique case (cmd.mode)
      tlj_pkg::MODE_FULL: begin
        if (!idx_last) begin
          out_sp_nxt = sat_sp(base_sum);
        end else if (line_cnt_r == CW'(1)) begin
          out_sp_nxt = sat_sp(XW'(spare));
        end
        out_lr_nxt = idx_last && !oversize && !last_r;
      end
      tlj_pkg::MODE_LAST: begin
        out_sp_nxt = idx_last ? sat_sp(tail) : tlj_pkg::SP_W'(1);
        out_lr_nxt = idx_last;
      end
      tlj_pkg::MODE_OVS: begin
        out_len_nxt = len_r;
        out_eol_nxt = 1'b1;
        out_ovs_nxt = 1'b1;
        out_lr_nxt  = 1'b1;
      end
      default: begin
        out_len_nxt = len_r;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_len_r <= out_len_nxt;
      out_sp_r  <= out_sp_nxt;
      out_eol_r <= out_eol_nxt;
      out_ovs_r <= out_ovs_nxt;
      out_lr_r  <= out_lr_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_word_length  = out_len_r;
  assign out_spaces_after = out_sp_r;
  assign out_end_of_line  = out_eol_r;
  assign out_oversize     = out_ovs_r;
  assign out_last_result  = out_lr_r;

  // Status to the controller.
  always_comb begin
    sts            = '0;
    sts.oversize   = oversize;
    sts.flush_full = (line_cnt_r != '0) && (oversize || at_cap || overflow);
    sts.last_word  = last_r;
    sts.div_done   = div_cnt_r == '0;
    sts.idx_last   = idx_last;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // The line never holds more words than the buffer has entries.
  `TLJ_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, line_cnt_r <= CW'(LINE_CAP))
  // The buffer is read only once the divider has finished.
  `TLJ_ASSERT_IMP(a_rd_div_idle, clk, rst_n, cmd.rd, div_cnt_r == '0)
  // An emitted word is shown on the next cycle.
  `TLJ_ASSERT_NXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid_r)

endmodule

`default_nettype wire

FILE: rtl/tlj_ctrl.sv
// ----------------------------------------------------------------------------
// tlj_ctrl
// Sequencer of the line justifier: accepts a word, decides on a flush,
// drives the divider, the buffer reads and the emission of result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_line_justifier_assert.svh"

module tlj_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output tlj_pkg::cmd_t       cmd,
  input  wire tlj_pkg::sts_t  sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_APPEND = 3'd5;
  localparam logic [2:0] S_OVS    = 3'd6;

  logic [2:0]                   state_r;
  logic [2:0]                   state_nxt;
  logic [tlj_pkg::MODE_W-1:0]   mode_r;
  logic [tlj_pkg::MODE_W-1:0]   mode_nxt;

  // State and mode registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= tlj_pkg::MODE_FULL;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.mode  = mode_r;
    unique case (state_r)
      S_IDLE: begin
        // No word is taken while reset is held.
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.flush_full) begin
          cmd.div_start = 1'b1;
          cmd.idx_clr   = 1'b1;
          mode_nxt      = tlj_pkg::MODE_FULL;
          state_nxt     = S_DIV;
        end else if (sts.oversize) begin
          state_nxt = S_OVS;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.idx_last) begin
            cmd.line_clr = 1'b1;
            if (mode_r == tlj_pkg::MODE_FULL) begin
              state_nxt = sts.oversize ? S_OVS : S_APPEND;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        if (sts.last_word) begin
          cmd.idx_clr = 1'b1;
          mode_nxt    = tlj_pkg::MODE_LAST;
          state_nxt   = S_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OVS: begin
        cmd.mode = tlj_pkg::MODE_OVS;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A word is loaded into the output register only when it has room.
  `TLJ_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, sts.out_free)
  // A word joins the line only when it fits and the line needs no flush.
  `TLJ_ASSERT_IMP(a_append_fits, clk, rst_n, cmd.append, !sts.flush_full && !sts.oversize)
  // Emission always starts from a fresh buffer read.
  `TLJ_ASSERT_NXT(a_read_emit, clk, rst_n, cmd.rd, state_r == S_EMIT)

endmodule

`default_nettype wire
